// File: rtl/per_id_min_interval_tracker_defines.svh
// ----------------------------------------------------------------------------
// per_id_min_interval_tracker_defines
// Assertion macros shared by the lap tracker RTL.
// ----------------------------------------------------------------------------
`ifndef PER_ID_MIN_INTERVAL_TRACKER_DEFINES_SVH
`define PER_ID_MIN_INTERVAL_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define PMIT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define PMIT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PMIT_ASSERT(name, prop, msg)
`define PMIT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: rtl/pmit_pkg.sv
// ----------------------------------------------------------------------------
// pmit_pkg
// Shared constants and types of the per-kart lap tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pmit_pkg;

  localparam int KART_SLOTS_DEF = 256;
  localparam int TIME_BITS_DEF  = 20;
  localparam int KART_W         = 8;

  localparam logic MODE_CROSSING = 1'b0;
  localparam logic MODE_CLEAR    = 1'b1;

  // per-kart status bits, kept in their own memory so they can be swept
  typedef struct packed {
    logic seen;
    logic has_best;
  } marks_t;

  localparam int MARKS_W = $bits(marks_t);

endpackage

`default_nettype wire

// File: rtl/per_id_min_interval_tracker.sv
// ----------------------------------------------------------------------------
// per_id_min_interval_tracker
// Per-kart lap timer: lap time, per-kart best lap and overall best lap.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o | mode_i, kart_id_i, crossing_time_i
//  out     | out_valid_o/ out_stall_i| lap_valid_o, lap_time_o,
//          |                         | kart_best_lap_o, overall_valid_o,
//          |                         | overall_kart_o, overall_best_o
//
// One crossing per cycle sustained unless stalled; the result passes the read
// stage and then the output register. Rate is set by the read-modify-write of
// the mark and data RAMs, with a bypass for the same kart in consecutive cycles.
// After reset and after every clear request the mark RAM is swept, one entry
// a cycle, over all KART_SLOTS entries, with in_stall_o high.
// A stalled output holds the result; one more item may sit in the read stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_id_min_interval_tracker_defines.svh"

module per_id_min_interval_tracker #(
  parameter int KART_SLOTS = pmit_pkg::KART_SLOTS_DEF,
  parameter int TIME_BITS  = pmit_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          mode_i,
  input  wire logic [pmit_pkg::KART_W-1:0]   kart_id_i,
  input  wire logic [TIME_BITS-1:0]          crossing_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               lap_valid_o,
  output logic signed [TIME_BITS:0]          lap_time_o,
  output logic signed [TIME_BITS:0]          kart_best_lap_o,
  output logic                               overall_valid_o,
  output logic [pmit_pkg::KART_W-1:0]        overall_kart_o,
  output logic signed [TIME_BITS:0]          overall_best_o
);

  localparam int IDX_W  = $clog2(KART_SLOTS);
  localparam int KW     = pmit_pkg::KART_W;
  localparam int CMP_W  = (IDX_W + 1 > KW) ? IDX_W + 1 : KW;
  localparam int LAP_W  = TIME_BITS + 1;
  localparam int DATA_W = LAP_W + TIME_BITS;

  // ---------------- input side ----------------
  logic                 accept;
  logic                 in_range;
  logic [IDX_W-1:0]     in_idx;
  logic [CMP_W-1:0]     in_kart_ext;

  assign in_kart_ext = CMP_W'(kart_id_i);
  assign in_range    = in_kart_ext < CMP_W'(KART_SLOTS);
  assign in_idx      = in_kart_ext[IDX_W-1:0];

  // ---------------- read stage ----------------
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_mode_q;
  logic [KW-1:0]        s1_kart_q;
  logic [TIME_BITS-1:0] s1_time_q;
  logic                 s1_range_q;
  logic [IDX_W-1:0]     s1_idx_q;
  logic                 s1_done;
  logic                 s1_wr_en;

  // sweep
  logic                 sweep_q, sweep_d;
  logic [IDX_W-1:0]     sweep_cnt_q, sweep_cnt_d;

  // bypass of the write done in the cycle the current item was read
  logic                 fwd_q, fwd_d;
  pmit_pkg::marks_t     wr_marks_q;
  logic [DATA_W-1:0]    wr_data_q;

  // output register
  logic                 out_valid_q, out_valid_d;

  // overall best
  logic                 found_q, found_d;
  logic [KW-1:0]        ovk_q, ovk_d;
  logic signed [LAP_W-1:0] ovb_q, ovb_d;

  assign s1_done    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = sweep_q ||
                      (s1_valid_q && (s1_mode_q == pmit_pkg::MODE_CLEAR || !s1_done));
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !s1_done);

  // ---------------- memories ----------------
  pmit_pkg::marks_t     mark_rdata;
  logic [pmit_pkg::MARKS_W-1:0] mark_rdata_raw;
  pmit_pkg::marks_t     mark_wdata;
  logic                 mark_we;
  logic [IDX_W-1:0]     mark_waddr;
  logic [DATA_W-1:0]    data_rdata;
  logic [DATA_W-1:0]    data_wdata;

  assign mark_we    = sweep_q || s1_wr_en;
  assign mark_waddr = sweep_q ? sweep_cnt_q : s1_idx_q;

  pmit_ram #(
    .WIDTH (pmit_pkg::MARKS_W),
    .DEPTH (KART_SLOTS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (sweep_q ? '0 : mark_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (mark_rdata_raw)
  );

  assign mark_rdata = pmit_pkg::marks_t'(mark_rdata_raw);

  pmit_ram #(
    .WIDTH (DATA_W),
    .DEPTH (KART_SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (s1_wr_en),
    .waddr_i (s1_idx_q),
    .wdata_i (data_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (data_rdata)
  );

  // ---------------- modify ----------------
  pmit_pkg::marks_t        marks_cur;
  logic [DATA_W-1:0]       data_cur;
  logic [TIME_BITS-1:0]    last_cur;
  logic signed [LAP_W-1:0] best_cur;
  logic signed [LAP_W-1:0] lap;
  logic                    take_best;
  logic signed [LAP_W-1:0] kbest;
  logic                    lap_valid;
  logic                    upd_overall;

  assign marks_cur = fwd_q ? wr_marks_q : mark_rdata;
  assign data_cur  = fwd_q ? wr_data_q  : data_rdata;
  assign last_cur  = data_cur[TIME_BITS-1:0];
  assign best_cur  = $signed(data_cur[DATA_W-1 -: LAP_W]);

  assign lap       = $signed({1'b0, s1_time_q}) - $signed({1'b0, last_cur});
  assign take_best = !marks_cur.has_best || (lap < best_cur);
  assign kbest     = take_best ? lap : best_cur;
  assign lap_valid = (s1_mode_q == pmit_pkg::MODE_CROSSING) && s1_range_q && marks_cur.seen;
  assign s1_wr_en  = s1_done && (s1_mode_q == pmit_pkg::MODE_CROSSING) && s1_range_q;

  assign upd_overall = lap_valid &&
                       (!found_q || (kbest < ovb_q) || ((kbest == ovb_q) && (s1_kart_q < ovk_q)));

  always_comb begin
    mark_wdata.seen     = 1'b1;
    mark_wdata.has_best = marks_cur.has_best || marks_cur.seen;
    data_wdata          = {(marks_cur.seen ? kbest : best_cur), s1_time_q};
  end

  always_comb begin
    found_d = found_q;
    ovk_d   = ovk_q;
    ovb_d   = ovb_q;
    if (s1_done) begin
      if (s1_mode_q == pmit_pkg::MODE_CLEAR) begin
        found_d = 1'b0;
        ovk_d   = '0;
        ovb_d   = '0;
      end else if (upd_overall) begin
        found_d = 1'b1;
        ovk_d   = s1_kart_q;
        ovb_d   = kbest;
      end
    end
  end

  always_comb begin
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    if (sweep_q) begin
      sweep_cnt_d = sweep_cnt_q + 1'b1;
      if (sweep_cnt_q == IDX_W'(KART_SLOTS - 1)) begin
        sweep_d     = 1'b0;
        sweep_cnt_d = '0;
      end
    end else if (s1_done && s1_mode_q == pmit_pkg::MODE_CLEAR) begin
      sweep_d     = 1'b1;
      sweep_cnt_d = '0;
    end
  end

  assign fwd_d       = accept && s1_wr_en && (s1_idx_q == in_idx);
  assign out_valid_d = s1_done || (out_valid_q && out_stall_i);

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      fwd_q       <= 1'b0;
      found_q     <= 1'b0;
      ovk_q       <= '0;
      ovb_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      if (accept) begin
        fwd_q <= fwd_d;
      end
      found_q     <= found_d;
      ovk_q       <= ovk_d;
      ovb_q       <= ovb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_i;
      s1_kart_q  <= kart_id_i;
      s1_time_q  <= crossing_time_i;
      s1_range_q <= in_range;
      s1_idx_q   <= in_idx;
    end
    if (s1_wr_en) begin
      wr_marks_q <= mark_wdata;
      wr_data_q  <= data_wdata;
    end
    if (s1_done) begin
      lap_valid_o     <= lap_valid;
      lap_time_o      <= lap_valid ? lap : '0;
      kart_best_lap_o <= lap_valid ? kbest : '0;
      overall_valid_o <= found_d;
      overall_kart_o  <= ovk_d;
      overall_best_o  <= ovb_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------- assertions ----------------
  `PMIT_ASSERT(a_no_xfer_in_sweep, sweep_q |-> in_stall_o,
               "input transfer during mark sweep")
  `PMIT_ASSERT(a_clear_starts_sweep,
               (s1_done && s1_mode_q == pmit_pkg::MODE_CLEAR) |=> sweep_q,
               "clear request did not start sweep")
  `PMIT_ASSERT(a_lap_implies_overall, (out_valid_o && lap_valid_o) |-> overall_valid_o,
               "lap reported without overall best")
  `PMIT_ASSERT(a_overall_le_kart,
               (out_valid_o && lap_valid_o) |-> (overall_best_o <= kart_best_lap_o),
               "overall best above kart best")
  // registers are unknown before the first edge of reset, so check from the next edge
  `PMIT_ASSERT_ALWAYS(a_reset_sweeps, !rst_ni |=> in_stall_o,
                      "input not stalled after reset")

endmodule

`default_nettype wire

// File: rtl/pmit_ram.sv
// ----------------------------------------------------------------------------
// pmit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
